FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ntt_pkg.sv
// ---------------------------------------------------------------------------
// ntt_pkg
// Types, parse positions, term kinds and delimiter bytes for the N-Triples
// term tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package ntt_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_pos;
    typedef logic [3:0] t_kind;
    typedef logic [1:0] t_lvl;

    // parse positions (state codes)
    localparam t_pos POS_SUBJ       = 4'd0;
    localparam t_pos POS_SUBJ_IRI   = 4'd1;
    localparam t_pos POS_SUBJ_BLANK = 4'd2;
    localparam t_pos POS_PRED       = 4'd3;
    localparam t_pos POS_PRED_IRI   = 4'd4;
    localparam t_pos POS_OBJ        = 4'd5;
    localparam t_pos POS_OBJ_IRI    = 4'd6;
    localparam t_pos POS_OBJ_BLANK  = 4'd7;
    localparam t_pos POS_LIT_VALUE  = 4'd8;
    localparam t_pos POS_LIT_AFTER  = 4'd9;
    localparam t_pos POS_LANG       = 4'd10;
    localparam t_pos POS_LANG_WS    = 4'd11;
    localparam t_pos POS_CARET1     = 4'd12;
    localparam t_pos POS_DT         = 4'd13;
    localparam t_pos POS_DT_IRI     = 4'd14;
    localparam t_pos POS_END        = 4'd15;

    // statement levels a fall-through can land on
    localparam t_lvl LVL_SUBJ = 2'd0;
    localparam t_lvl LVL_PRED = 2'd1;
    localparam t_lvl LVL_OBJ  = 2'd2;
    localparam t_lvl LVL_END  = 2'd3;

    // term kinds
    localparam t_kind K_NONE      = 4'd0;
    localparam t_kind K_SUBJ_IRI  = 4'd1;
    localparam t_kind K_SUBJ_BLK  = 4'd2;
    localparam t_kind K_PRED_IRI  = 4'd3;
    localparam t_kind K_OBJ_IRI   = 4'd4;
    localparam t_kind K_LITERAL   = 4'd5;
    localparam t_kind K_LANG      = 4'd6;
    localparam t_kind K_DTYPE     = 4'd7;
    localparam t_kind K_OBJ_BLK   = 4'd8;

    // delimiter bytes
    localparam t_byte CH_LT    = 8'h3C;
    localparam t_byte CH_GT    = 8'h3E;
    localparam t_byte CH_QUOTE = 8'h22;
    localparam t_byte CH_AT    = 8'h40;
    localparam t_byte CH_CARET = 8'h5E;
    localparam t_byte CH_UNDER = 8'h5F;
    localparam t_byte CH_DOT   = 8'h2E;

    // parser state carried from byte to byte
    typedef struct packed {
        t_pos pos;
        logic have_subj;
        logic have_pred;
        logic have_obj;
        logic prefix_skip;
    } t_parse_state;

    // per-byte result
    typedef struct packed {
        t_kind kind;
        logic  is_text;
        logic  closed;
        logic  stmt_end;
        logic  stmt_valid;
        logic  dropped;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/ntriples_term_tokenizer_core.sv
// ---------------------------------------------------------------------------
// ntriples_term_tokenizer_core
// Labels each byte of N-Triples text with its term, term ends and statement
// ends. Input register, one-pass parse logic, output register.
// ---------------------------------------------------------------------------
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready   | i_text_byte, i_final_byte
//   out     | output    | o_out_valid / i_out_ready | o_term_kind .. o_byte_dropped
//
// One byte per cycle while the output is not stalled; every request gives
// exactly one result. The parse state register is updated as a byte
// moves from the input register to the output register, so consecutive
// bytes flow back to back. A stalled output holds its result and backs up
// into the input register, then o_in_ready drops. Synchronous active-low
// reset empties both registers and returns the parser to expecting a subject.
// ---------------------------------------------------------------------------
`default_nettype none

module ntriples_term_tokenizer_core
    import ntt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_final_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [3:0] o_term_kind,
    output logic       o_is_term_text,
    output logic       o_term_closed,
    output logic       o_statement_end,
    output logic       o_statement_valid,
    output logic       o_byte_dropped
);

    logic         r_in_valid;
    t_byte        r_byte;
    logic         r_fin;
    logic         r_out_valid;
    t_result      r_res;
    t_parse_state r_state;
    t_parse_state n_state;
    t_result      n_res;
    logic         out_take;
    logic         in_take;

    // pipeline moves when the next register is free or being emptied
    assign out_take   = !r_out_valid || i_out_ready;
    assign in_take    = !r_in_valid || out_take;
    assign o_in_ready = in_take;

    ntt_step u_step (
        .i_state      (r_state),
        .i_text_byte  (r_byte),
        .i_final_byte (r_fin),
        .o_state      (n_state),
        .o_result     (n_res)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
        if (in_take && i_in_valid) begin
            r_byte <= i_text_byte;
            r_fin  <= i_final_byte;
        end
    end

    // parse state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '{pos: POS_SUBJ, default: 1'b0};
        end else if (out_take) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
        if (out_take && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_term_kind       = r_res.kind;
    assign o_is_term_text    = r_res.is_text;
    assign o_term_closed     = r_res.closed;
    assign o_statement_end   = r_res.stmt_end;
    assign o_statement_valid = r_res.stmt_valid;
    assign o_byte_dropped    = r_res.dropped;

endmodule

`default_nettype wire

FILE: rtl/core/ntt_step.sv
// ---------------------------------------------------------------------------
// ntt_step
// Combinational next-state and result logic for one text byte: resolves
// the fall-through between positions in a single pass.
// ---------------------------------------------------------------------------
`default_nettype none

module ntt_step
    import ntt_pkg::*;
(
    input  t_parse_state i_state,
    input  t_byte        i_text_byte,
    input  logic         i_final_byte,
    output t_parse_state o_state,
    output t_result      o_result
);

    logic         ws;
    t_parse_state st;
    t_result      res;
    logic         caret0_try;
    logic         dt_try;
    logic         go_lvl;
    t_lvl         lvl;

    assign ws = i_text_byte inside {8'd32, [8'd9:8'd13]};

    always_comb begin
        st         = i_state;
        res        = '0;
        caret0_try = 1'b0;
        dt_try     = 1'b0;
        go_lvl     = 1'b0;
        lvl        = LVL_SUBJ;

        // handling at the stored position
        case (i_state.pos)
            POS_SUBJ: begin
                go_lvl = 1'b1;
                lvl    = LVL_SUBJ;
            end
            POS_PRED: begin
                go_lvl = 1'b1;
                lvl    = LVL_PRED;
            end
            POS_OBJ: begin
                go_lvl = 1'b1;
                lvl    = LVL_OBJ;
            end
            POS_END: begin
                go_lvl = 1'b1;
                lvl    = LVL_END;
            end
            POS_SUBJ_IRI, POS_PRED_IRI, POS_OBJ_IRI, POS_DT_IRI: begin
                case (i_state.pos)
                    POS_SUBJ_IRI: res.kind = K_SUBJ_IRI;
                    POS_PRED_IRI: res.kind = K_PRED_IRI;
                    POS_OBJ_IRI:  res.kind = K_OBJ_IRI;
                    default:      res.kind = K_DTYPE;
                endcase
                if (i_text_byte == CH_GT) begin
                    res.closed = 1'b1;
                    case (i_state.pos)
                        POS_SUBJ_IRI: st.pos = POS_PRED;
                        POS_PRED_IRI: st.pos = POS_OBJ;
                        default:      st.pos = POS_END;
                    endcase
                end else begin
                    res.is_text = 1'b1;
                end
            end
            POS_SUBJ_BLANK, POS_OBJ_BLANK: begin
                res.kind = (i_state.pos == POS_SUBJ_BLANK) ? K_SUBJ_BLK : K_OBJ_BLK;
                if (i_state.prefix_skip) begin
                    st.prefix_skip = 1'b0;
                end else if (ws) begin
                    res.closed = 1'b1;
                    st.pos     = (i_state.pos == POS_SUBJ_BLANK) ? POS_PRED : POS_END;
                end else if (i_text_byte == CH_DOT) begin
                    // label ends at the dot, which goes on to the next position
                    res.closed = 1'b1;
                    go_lvl     = 1'b1;
                    lvl        = (i_state.pos == POS_SUBJ_BLANK) ? LVL_PRED : LVL_END;
                end else begin
                    res.is_text = 1'b1;
                end
            end
            POS_LIT_VALUE: begin
                res.kind = K_LITERAL;
                if (i_text_byte == CH_QUOTE) begin
                    res.closed = 1'b1;
                    st.pos     = POS_LIT_AFTER;
                end else begin
                    res.is_text = 1'b1;
                end
            end
            POS_LIT_AFTER: begin
                if (i_text_byte == CH_AT) begin
                    res.kind = K_LANG;
                    st.pos   = POS_LANG;
                end else begin
                    caret0_try = 1'b1;
                end
            end
            POS_LANG: begin
                res.kind = K_LANG;
                if (ws) begin
                    res.closed = 1'b1;
                    st.pos     = POS_LANG_WS;
                end else begin
                    res.is_text = 1'b1;
                end
            end
            POS_LANG_WS: begin
                if (!ws) begin
                    caret0_try = 1'b1;
                end
            end
            POS_CARET1: begin
                if (i_text_byte == CH_CARET) begin
                    st.pos = POS_DT;
                end else begin
                    dt_try = 1'b1;
                end
            end
            POS_DT: begin
                dt_try = 1'b1;
            end
            default: begin
                st.pos = POS_SUBJ;
            end
        endcase

        // first caret of a datatype marker
        if (caret0_try) begin
            if (i_text_byte == CH_CARET) begin
                st.pos = POS_CARET1;
            end else begin
                dt_try = 1'b1;
            end
        end

        // datatype IRI opener
        if (dt_try) begin
            if (i_text_byte == CH_LT) begin
                res.kind = K_DTYPE;
                st.pos   = POS_DT_IRI;
            end else begin
                go_lvl = 1'b1;
                lvl    = LVL_END;
            end
        end

        // statement level: open a term, skip whitespace, end the statement, or drop the byte
        if (go_lvl) begin
            if (ws) begin
                case (lvl)
                    LVL_SUBJ: st.pos = POS_SUBJ;
                    LVL_PRED: st.pos = POS_PRED;
                    LVL_OBJ:  st.pos = POS_OBJ;
                    default:  st.pos = POS_END;
                endcase
            end else if (i_text_byte == CH_DOT) begin
                res.stmt_end   = 1'b1;
                res.stmt_valid = st.have_subj & st.have_pred & st.have_obj;
                st             = '{pos: POS_SUBJ, default: 1'b0};
            end else if (lvl != LVL_END && (i_text_byte == CH_LT ||
                         i_text_byte == CH_UNDER || i_text_byte == CH_QUOTE)) begin
                if (i_text_byte == CH_QUOTE) begin
                    res.kind    = K_LITERAL;
                    st.pos      = POS_LIT_VALUE;
                    st.have_obj = 1'b1;
                end else if (i_text_byte == CH_UNDER) begin
                    st.prefix_skip = 1'b1;
                    if (lvl == LVL_SUBJ) begin
                        res.kind     = K_SUBJ_BLK;
                        st.pos       = POS_SUBJ_BLANK;
                        st.have_subj = 1'b1;
                    end else begin
                        res.kind    = K_OBJ_BLK;
                        st.pos      = POS_OBJ_BLANK;
                        st.have_obj = 1'b1;
                    end
                end else begin
                    case (lvl)
                        LVL_SUBJ: begin
                            res.kind     = K_SUBJ_IRI;
                            st.pos       = POS_SUBJ_IRI;
                            st.have_subj = 1'b1;
                        end
                        LVL_PRED: begin
                            res.kind     = K_PRED_IRI;
                            st.pos       = POS_PRED_IRI;
                            st.have_pred = 1'b1;
                        end
                        default: begin
                            res.kind    = K_OBJ_IRI;
                            st.pos      = POS_OBJ_IRI;
                            st.have_obj = 1'b1;
                        end
                    endcase
                end
            end else if (lvl == LVL_SUBJ) begin
                // nothing fits a statement that has not started
                res.dropped = 1'b1;
                st.pos      = POS_END;
            end else begin
                // end the statement, then retry the byte as a new subject
                res.stmt_end   = 1'b1;
                res.stmt_valid = st.have_subj & st.have_pred & st.have_obj;
                st             = '{pos: POS_SUBJ, default: 1'b0};
                if (i_text_byte == CH_LT) begin
                    res.kind     = K_SUBJ_IRI;
                    st.pos       = POS_SUBJ_IRI;
                    st.have_subj = 1'b1;
                end else if (i_text_byte == CH_UNDER) begin
                    res.kind       = K_SUBJ_BLK;
                    st.pos         = POS_SUBJ_BLANK;
                    st.have_subj   = 1'b1;
                    st.prefix_skip = 1'b1;
                end else if (i_text_byte == CH_QUOTE) begin
                    res.kind    = K_LITERAL;
                    st.pos      = POS_LIT_VALUE;
                    st.have_obj = 1'b1;
                end else begin
                    res.dropped = 1'b1;
                    st.pos      = POS_END;
                end
            end
        end

        // last byte closes any open term and statement
        if (i_final_byte) begin
            if (st.pos inside {POS_SUBJ_IRI, POS_SUBJ_BLANK, POS_PRED_IRI, POS_OBJ_IRI,
                               POS_OBJ_BLANK, POS_LIT_VALUE, POS_LANG, POS_DT_IRI}) begin
                res.closed = 1'b1;
            end
            if (st.pos != POS_SUBJ && !res.stmt_end) begin
                res.stmt_end   = 1'b1;
                res.stmt_valid = st.have_subj & st.have_pred & st.have_obj;
            end
            st = '{pos: POS_SUBJ, default: 1'b0};
        end
    end

    assign o_state  = st;
    assign o_result = res;

endmodule

`default_nettype wire

FILE: rtl/core/ntt_checker.sv
// ---------------------------------------------------------------------------
// ntt_checker
// Port-level checks on the tokenizer output, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ntt_checker
    import ntt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic [3:0] o_term_kind,
    input  logic       o_is_term_text,
    input  logic       o_term_closed,
    input  logic       o_statement_end,
    input  logic       o_statement_valid,
    input  logic       o_byte_dropped
);

    // a stalled result stays offered
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "output request dropped while stalled")

    // validity only comes with a statement end
    `ASSERT_IMP(a_valid_end, i_clk, i_rst_n, o_out_valid && o_statement_valid, o_statement_end, "statement_valid without statement_end")

    // a dropped byte belongs to no term
    `ASSERT_IMP(a_drop_none, i_clk, i_rst_n, o_out_valid && o_byte_dropped, o_term_kind == K_NONE && !o_is_term_text && !o_term_closed, "dropped byte carries term marks")

    // term content always names its term
    `ASSERT_IMP(a_text_kind, i_clk, i_rst_n, o_out_valid && o_is_term_text, o_term_kind != K_NONE, "term text without a term kind")

endmodule

bind ntriples_term_tokenizer_core ntt_checker u_ntt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_term_kind       (o_term_kind),
    .o_is_term_text    (o_is_term_text),
    .o_term_closed     (o_term_closed),
    .o_statement_end   (o_statement_end),
    .o_statement_valid (o_statement_valid),
    .o_byte_dropped    (o_byte_dropped)
);

`default_nettype wire
